// ===== sv/marching_cubes_cell_triangulator_top_assert.svh =====
// Assertion macros used by the triangulator controller (mcct_ctrl).
// Each macro expects clk and rst to exist in the module that uses it.
`ifndef MARCHING_CUBES_CELL_TRIANGULATOR_TOP_ASSERT_SVH
`define MARCHING_CUBES_CELL_TRIANGULATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define MCCT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define MCCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/mcct_pkg.sv =====
`default_nettype none
package mcct_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_BITS    = COORD_BITS + FRAC_BITS + 1;
  localparam int SF_BITS     = COORD_BITS + FRAC_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + SF_BITS;
  localparam int ROW_BITS    = 60;
  localparam int DIV_STEPS   = SF_BITS;

  // configuration register indexes
  localparam logic REG_ISO_THRESH     = 1'b0;
  localparam logic REG_MIN_DIFFERENCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOKUP, ST_RD0, ST_RD1, ST_CALC, ST_MUL, ST_DIV, ST_FIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       lookup;
    logic       rd0;
    logic       rd1;
    logic       calc;
    logic       mul;
    logic       div_step;
    logic       fin;
    logic [2:0] tri_idx;
    logic [1:0] vert_idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] ntri;
    logic       skip;
  } stat_t;

  // corner bits: bit0 x, bit1 y, bit2 z
  function automatic logic [2:0] corner_pos(input logic [2:0] c);
    logic [2:0] p;
    case (c)
      3'd0: p = 3'd0;
      3'd1: p = 3'd1;
      3'd2: p = 3'd5;
      3'd3: p = 3'd4;
      3'd4: p = 3'd2;
      3'd5: p = 3'd3;
      3'd6: p = 3'd7;
      3'd7: p = 3'd6;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // edge endpoints {first, second}
  function automatic logic [5:0] edge_ends(input logic [3:0] e);
    logic [5:0] r;
    case (e)
      4'd0:  r = {3'd0, 3'd1};
      4'd1:  r = {3'd1, 3'd2};
      4'd2:  r = {3'd2, 3'd3};
      4'd3:  r = {3'd3, 3'd0};
      4'd4:  r = {3'd4, 3'd5};
      4'd5:  r = {3'd5, 3'd6};
      4'd6:  r = {3'd6, 3'd7};
      4'd7:  r = {3'd7, 3'd4};
      4'd8:  r = {3'd0, 3'd4};
      4'd9:  r = {3'd1, 3'd5};
      4'd10: r = {3'd2, 3'd6};
      4'd11: r = {3'd3, 3'd7};
      default: r = {3'd0, 3'd1};
    endcase
    return r;
  endfunction

  // {triangle count, edge digits right-aligned, first edge most significant}
  function automatic logic [62:0] tri_entry(input logic [7:0] idx);
    logic [62:0] e;
    case (idx)
      8'd0: e = {3'd0, 60'h0};
      8'd1: e = {3'd1, 60'h083};
      8'd2: e = {3'd1, 60'h019};
      8'd3: e = {3'd2, 60'h183981};
      8'd4: e = {3'd1, 60'h12a};
      8'd5: e = {3'd2, 60'h08312a};
      8'd6: e = {3'd2, 60'h92a029};
      8'd7: e = {3'd3, 60'h2832a8a98};
      8'd8: e = {3'd1, 60'h3b2};
      8'd9: e = {3'd2, 60'h0b28b0};
      8'd10: e = {3'd2, 60'h19023b};
      8'd11: e = {3'd3, 60'h1b219b98b};
      8'd12: e = {3'd2, 60'h3a1ba3};
      8'd13: e = {3'd3, 60'h0a108a8ba};
      8'd14: e = {3'd3, 60'h3903b9ba9};
      8'd15: e = {3'd2, 60'h98aa8b};
      8'd16: e = {3'd1, 60'h478};
      8'd17: e = {3'd2, 60'h430734};
      8'd18: e = {3'd2, 60'h019847};
      8'd19: e = {3'd3, 60'h419471731};
      8'd20: e = {3'd2, 60'h12a847};
      8'd21: e = {3'd3, 60'h34730412a};
      8'd22: e = {3'd3, 60'h92a902847};
      8'd23: e = {3'd4, 60'h2a9297273794};
      8'd24: e = {3'd2, 60'h8473b2};
      8'd25: e = {3'd3, 60'hb47b24204};
      8'd26: e = {3'd3, 60'h90184723b};
      8'd27: e = {3'd4, 60'h47b94b9b2921};
      8'd28: e = {3'd3, 60'h3a13ba784};
      8'd29: e = {3'd4, 60'h1ba14b1047b4};
      8'd30: e = {3'd4, 60'h47890b9bab03};
      8'd31: e = {3'd3, 60'h47b4b99ba};
      8'd32: e = {3'd1, 60'h954};
      8'd33: e = {3'd2, 60'h954083};
      8'd34: e = {3'd2, 60'h054150};
      8'd35: e = {3'd3, 60'h854835315};
      8'd36: e = {3'd2, 60'h12a954};
      8'd37: e = {3'd3, 60'h30812a495};
      8'd38: e = {3'd3, 60'h52a542402};
      8'd39: e = {3'd4, 60'h2a5325354348};
      8'd40: e = {3'd2, 60'h95423b};
      8'd41: e = {3'd3, 60'h0b208b495};
      8'd42: e = {3'd3, 60'h05401523b};
      8'd43: e = {3'd4, 60'h21525828b485};
      8'd44: e = {3'd3, 60'ha3ba13954};
      8'd45: e = {3'd4, 60'h4950818a18ba};
      8'd46: e = {3'd4, 60'h54050b5bab03};
      8'd47: e = {3'd3, 60'h54858aa8b};
      8'd48: e = {3'd2, 60'h978579};
      8'd49: e = {3'd3, 60'h930953573};
      8'd50: e = {3'd3, 60'h078017157};
      8'd51: e = {3'd2, 60'h153357};
      8'd52: e = {3'd3, 60'h978957a12};
      8'd53: e = {3'd4, 60'ha12950530573};
      8'd54: e = {3'd4, 60'h802825857a52};
      8'd55: e = {3'd3, 60'h2a5253357};
      8'd56: e = {3'd3, 60'h7957893b2};
      8'd57: e = {3'd4, 60'h95797292027b};
      8'd58: e = {3'd4, 60'h23b018178157};
      8'd59: e = {3'd3, 60'hb21b17715};
      8'd60: e = {3'd4, 60'h958857a13a3b};
      8'd61: e = {3'd5, 60'h5705097b010aba0};
      8'd62: e = {3'd5, 60'hba0b03a50807570};
      8'd63: e = {3'd2, 60'hba57b5};
      8'd64: e = {3'd1, 60'ha65};
      8'd65: e = {3'd2, 60'h0835a6};
      8'd66: e = {3'd2, 60'h9015a6};
      8'd67: e = {3'd3, 60'h1831985a6};
      8'd68: e = {3'd2, 60'h165261};
      8'd69: e = {3'd3, 60'h165126308};
      8'd70: e = {3'd3, 60'h965906026};
      8'd71: e = {3'd4, 60'h598582526328};
      8'd72: e = {3'd2, 60'h23ba65};
      8'd73: e = {3'd3, 60'hb08b20a65};
      8'd74: e = {3'd3, 60'h01923b5a6};
      8'd75: e = {3'd4, 60'h5a61929b298b};
      8'd76: e = {3'd3, 60'h63b653513};
      8'd77: e = {3'd4, 60'h08b0b50515b6};
      8'd78: e = {3'd4, 60'h3b6036065059};
      8'd79: e = {3'd3, 60'h65969bb98};
      8'd80: e = {3'd2, 60'h5a6478};
      8'd81: e = {3'd3, 60'h43047365a};
      8'd82: e = {3'd3, 60'h1905a6847};
      8'd83: e = {3'd4, 60'ha65197173794};
      8'd84: e = {3'd3, 60'h612651478};
      8'd85: e = {3'd4, 60'h125526304347};
      8'd86: e = {3'd4, 60'h847905065026};
      8'd87: e = {3'd5, 60'h739794329596269};
      8'd88: e = {3'd3, 60'h3b2784a65};
      8'd89: e = {3'd4, 60'h5a647242027b};
      8'd90: e = {3'd4, 60'h01947823b5a6};
      8'd91: e = {3'd5, 60'h9219b294b7b45a6};
      8'd92: e = {3'd4, 60'h8473b53515b6};
      8'd93: e = {3'd5, 60'h51b5b610b7b404b};
      8'd94: e = {3'd5, 60'h059065036b63847};
      8'd95: e = {3'd4, 60'h65969b4797b9};
      8'd96: e = {3'd2, 60'ha4964a};
      8'd97: e = {3'd3, 60'h4a649a083};
      8'd98: e = {3'd3, 60'ha01a60640};
      8'd99: e = {3'd4, 60'h83181686461a};
      8'd100: e = {3'd3, 60'h149124264};
      8'd101: e = {3'd4, 60'h308129249264};
      8'd102: e = {3'd2, 60'h024426};
      8'd103: e = {3'd3, 60'h832824426};
      8'd104: e = {3'd3, 60'ha49a64b23};
      8'd105: e = {3'd4, 60'h08228b49a4a6};
      8'd106: e = {3'd4, 60'h3b201606461a};
      8'd107: e = {3'd5, 60'h64161a48121b8b1};
      8'd108: e = {3'd4, 60'h964936913b63};
      8'd109: e = {3'd5, 60'h8b1810b61914641};
      8'd110: e = {3'd3, 60'h3b6360064};
      8'd111: e = {3'd2, 60'h648b68};
      8'd112: e = {3'd3, 60'h7a678a89a};
      8'd113: e = {3'd4, 60'h0730a709a67a};
      8'd114: e = {3'd4, 60'ha671a7178180};
      8'd115: e = {3'd3, 60'ha67a71173};
      8'd116: e = {3'd4, 60'h126168189867};
      8'd117: e = {3'd5, 60'h269291679093739};
      8'd118: e = {3'd3, 60'h780706602};
      8'd119: e = {3'd2, 60'h732672};
      8'd120: e = {3'd4, 60'h23ba68a89867};
      8'd121: e = {3'd5, 60'h20727b09767a9a7};
      8'd122: e = {3'd5, 60'h1801781a767a23b};
      8'd123: e = {3'd4, 60'hb21b17a61671};
      8'd124: e = {3'd5, 60'h896867916b63136};
      8'd125: e = {3'd2, 60'h091b67};
      8'd126: e = {3'd4, 60'h7807063b0b60};
      8'd127: e = {3'd1, 60'h7b6};
      8'd128: e = {3'd1, 60'h76b};
      8'd129: e = {3'd2, 60'h308b76};
      8'd130: e = {3'd2, 60'h019b76};
      8'd131: e = {3'd3, 60'h819831b76};
      8'd132: e = {3'd2, 60'ha126b7};
      8'd133: e = {3'd3, 60'h12a3086b7};
      8'd134: e = {3'd3, 60'h2902a96b7};
      8'd135: e = {3'd4, 60'h6b72a3a83a98};
      8'd136: e = {3'd2, 60'h723627};
      8'd137: e = {3'd3, 60'h708760620};
      8'd138: e = {3'd3, 60'h276237019};
      8'd139: e = {3'd4, 60'h162186198876};
      8'd140: e = {3'd3, 60'ha76a17137};
      8'd141: e = {3'd4, 60'ha7617a187108};
      8'd142: e = {3'd4, 60'h03707a0a96a7};
      8'd143: e = {3'd3, 60'h76a7a88a9};
      8'd144: e = {3'd2, 60'h684b86};
      8'd145: e = {3'd3, 60'h36b306046};
      8'd146: e = {3'd3, 60'h86b846901};
      8'd147: e = {3'd4, 60'h946963931b36};
      8'd148: e = {3'd3, 60'h6846b82a1};
      8'd149: e = {3'd4, 60'h12a30b06b046};
      8'd150: e = {3'd4, 60'h4b846b0292a9};
      8'd151: e = {3'd5, 60'ha93a32943b36463};
      8'd152: e = {3'd3, 60'h823842462};
      8'd153: e = {3'd2, 60'h042462};
      8'd154: e = {3'd4, 60'h190234246438};
      8'd155: e = {3'd3, 60'h194142246};
      8'd156: e = {3'd4, 60'h8138618466a1};
      8'd157: e = {3'd3, 60'ha10a06604};
      8'd158: e = {3'd5, 60'h4634386a3039a93};
      8'd159: e = {3'd2, 60'ha946a4};
      8'd160: e = {3'd2, 60'h49576b};
      8'd161: e = {3'd3, 60'h083495b76};
      8'd162: e = {3'd3, 60'h50154076b};
      8'd163: e = {3'd4, 60'hb76834354315};
      8'd164: e = {3'd3, 60'h954a1276b};
      8'd165: e = {3'd4, 60'h6b712a083495};
      8'd166: e = {3'd4, 60'h76b54a42a402};
      8'd167: e = {3'd5, 60'h348354325a52b76};
      8'd168: e = {3'd3, 60'h723762549};
      8'd169: e = {3'd4, 60'h954086062687};
      8'd170: e = {3'd4, 60'h362376150540};
      8'd171: e = {3'd5, 60'h628687218485158};
      8'd172: e = {3'd4, 60'h954a16176137};
      8'd173: e = {3'd5, 60'h16a176107870954};
      8'd174: e = {3'd5, 60'h40a4a503a6a737a};
      8'd175: e = {3'd4, 60'h76a7a854a48a};
      8'd176: e = {3'd3, 60'h6956b9b89};
      8'd177: e = {3'd4, 60'h36b063056095};
      8'd178: e = {3'd4, 60'h0b805b01556b};
      8'd179: e = {3'd3, 60'h6b3635531};
      8'd180: e = {3'd4, 60'h12a95b9b8b56};
      8'd181: e = {3'd5, 60'h0b306b09656912a};
      8'd182: e = {3'd5, 60'hb85b56805a52025};
      8'd183: e = {3'd4, 60'h6b36352a3a53};
      8'd184: e = {3'd4, 60'h589528562382};
      8'd185: e = {3'd3, 60'h956960062};
      8'd186: e = {3'd5, 60'h158180568382628};
      8'd187: e = {3'd2, 60'h156216};
      8'd188: e = {3'd5, 60'h13616a386569896};
      8'd189: e = {3'd4, 60'ha10a06950560};
      8'd190: e = {3'd2, 60'h03856a};
      8'd191: e = {3'd1, 60'ha56};
      8'd192: e = {3'd2, 60'hb5a75b};
      8'd193: e = {3'd3, 60'hb5ab75830};
      8'd194: e = {3'd3, 60'h5b75ab190};
      8'd195: e = {3'd4, 60'ha75ab7981831};
      8'd196: e = {3'd3, 60'hb12b71751};
      8'd197: e = {3'd4, 60'h08312717572b};
      8'd198: e = {3'd4, 60'h9759279022b7};
      8'd199: e = {3'd5, 60'h75272b592328982};
      8'd200: e = {3'd3, 60'h25a235375};
      8'd201: e = {3'd4, 60'h820852875a25};
      8'd202: e = {3'd4, 60'h9015a35373a2};
      8'd203: e = {3'd5, 60'h982921872a25752};
      8'd204: e = {3'd2, 60'h135375};
      8'd205: e = {3'd3, 60'h087071175};
      8'd206: e = {3'd3, 60'h903935537};
      8'd207: e = {3'd2, 60'h987597};
      8'd208: e = {3'd3, 60'h5845a8ab8};
      8'd209: e = {3'd4, 60'h5045b05abb30};
      8'd210: e = {3'd4, 60'h01984a8aba45};
      8'd211: e = {3'd5, 60'hab4a45b34941314};
      8'd212: e = {3'd4, 60'h2512852b8458};
      8'd213: e = {3'd5, 60'h04b0b345b2b151b};
      8'd214: e = {3'd5, 60'h0250592b5458b85};
      8'd215: e = {3'd2, 60'h9452b3};
      8'd216: e = {3'd4, 60'h25a352345384};
      8'd217: e = {3'd3, 60'h5a2524420};
      8'd218: e = {3'd5, 60'h3a235a385458019};
      8'd219: e = {3'd4, 60'h5a2524192942};
      8'd220: e = {3'd3, 60'h845853351};
      8'd221: e = {3'd2, 60'h045105};
      8'd222: e = {3'd4, 60'h845853905035};
      8'd223: e = {3'd1, 60'h945};
      8'd224: e = {3'd3, 60'h4b749b9ab};
      8'd225: e = {3'd4, 60'h0834979b79ab};
      8'd226: e = {3'd4, 60'h1ab1b414074b};
      8'd227: e = {3'd5, 60'h3143481a474bab4};
      8'd228: e = {3'd4, 60'h4b79b492b912};
      8'd229: e = {3'd5, 60'h9749b791b2b1083};
      8'd230: e = {3'd3, 60'hb74b42240};
      8'd231: e = {3'd4, 60'hb74b42834324};
      8'd232: e = {3'd4, 60'h29a279237749};
      8'd233: e = {3'd5, 60'h9a7974a27870207};
      8'd234: e = {3'd5, 60'h37a3a274a1a040a};
      8'd235: e = {3'd2, 60'h1a2874};
      8'd236: e = {3'd3, 60'h491417713};
      8'd237: e = {3'd4, 60'h491417081871};
      8'd238: e = {3'd2, 60'h403743};
      8'd239: e = {3'd1, 60'h487};
      8'd240: e = {3'd2, 60'h9a8ab8};
      8'd241: e = {3'd3, 60'h30939bb9a};
      8'd242: e = {3'd3, 60'h01a0a88ab};
      8'd243: e = {3'd2, 60'h31ab3a};
      8'd244: e = {3'd3, 60'h12b1b99b8};
      8'd245: e = {3'd4, 60'h30939b1292b9};
      8'd246: e = {3'd2, 60'h02b80b};
      8'd247: e = {3'd1, 60'h32b};
      8'd248: e = {3'd3, 60'h23828aa89};
      8'd249: e = {3'd2, 60'h9a2092};
      8'd250: e = {3'd4, 60'h23828a0181a8};
      8'd251: e = {3'd1, 60'h1a2};
      8'd252: e = {3'd2, 60'h138918};
      8'd253: e = {3'd1, 60'h091};
      8'd254: e = {3'd1, 60'h038};
      default: e = {3'd0, 60'h0};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mcct_dp.sv =====
`default_nettype none
module mcct_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic signed [15:0]    corner_value_0,
  input  logic signed [15:0]    corner_value_1,
  input  logic signed [15:0]    corner_value_2,
  input  logic signed [15:0]    corner_value_3,
  input  logic signed [15:0]    corner_value_4,
  input  logic signed [15:0]    corner_value_5,
  input  logic signed [15:0]    corner_value_6,
  input  logic signed [15:0]    corner_value_7,
  input  logic signed [15:0]    base_x,
  input  logic signed [15:0]    base_y,
  input  logic signed [15:0]    base_z,
  input  logic [15:0]           cell_size,
  input  mcct_pkg::cmd_t        cmd,
  output mcct_pkg::stat_t       st,
  output logic signed [24:0]    first_x,
  output logic signed [24:0]    first_y,
  output logic signed [24:0]    first_z,
  output logic signed [24:0]    second_x,
  output logic signed [24:0]    second_y,
  output logic signed [24:0]    second_z,
  output logic signed [24:0]    third_x,
  output logic signed [24:0]    third_y,
  output logic signed [24:0]    third_z,
  output logic                  last_triangle
);
  import mcct_pkg::*;

  typedef enum logic [1:0] {OFF_DIV, OFF_MID, OFF_ZERO} off_mode_t;

  logic signed [15:0] iso_thresh;
  logic [15:0]        min_difference;
  logic signed [15:0] cv [8];
  logic [15:0]        bx, by, bz, cs;
  logic [ROW_BITS-1:0] row;
  logic [2:0]         ntri;
  logic [2:0]         c0, c1;
  logic signed [15:0] v0, v1;
  logic [15:0]        aa, ad;
  off_mode_t          mode;
  logic [15:0]        rem;
  logic [SF_BITS-1:0] qs;
  logic [OUT_BITS-1:0] vtx [3][3];

  logic [7:0]          idx;
  logic [62:0]         ent;
  logic [6:0]          sh;
  logic [3:0]          k;
  logic [ROW_BITS-1:0] rs;
  logic [3:0]          dig;
  logic [5:0]          ends;
  logic [2:0]          rd_sel;
  logic signed [16:0]  d, a;
  logic [16:0]         ad_w, aa_w;
  logic [SF_BITS-1:0]  sf;
  logic [PROD_BITS-1:0] prod;
  logic [16:0]         t;
  logic                ge;
  logic                rnd;
  logic [OUT_BITS-1:0] off;
  logic [OUT_BITS-1:0] basef [3];
  logic [OUT_BITS-1:0] crd [3];
  logic [2:0]          p0, p1;

  assign sf = {cs, {FRAC_BITS{1'b0}}};

  // cube index and table row
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      idx[i] = (cv[i] >= iso_thresh);
    end
    ent = tri_entry(idx);
    sh  = 7'd60 - 7'(ent[62:60]) * 7'd12;
  end

  // current edge from the row
  always_comb begin
    k      = 4'(cmd.tri_idx) * 4'd3 + 4'(cmd.vert_idx);
    rs     = row << {k, 2'b00};
    dig    = rs[ROW_BITS-1 -: 4];
    ends   = edge_ends((dig > 4'd11) ? 4'd0 : dig);
    rd_sel = cmd.rd0 ? ends[5:3] : c1;
  end

  // crossing terms
  always_comb begin
    d    = 17'(v1) - 17'(v0);
    a    = 17'(iso_thresh) - 17'(v0);
    ad_w = d[16] ? 17'(-d) : 17'(d);
    aa_w = a[16] ? 17'(-a) : 17'(a);
    prod = PROD_BITS'(aa) * PROD_BITS'(sf);
    t    = {rem, qs[SF_BITS-1]};
    ge   = (t >= {1'b0, ad});
    rnd  = ({rem, 1'b0} >= {1'b0, ad});
    case (mode)
      OFF_DIV:  off = OUT_BITS'(qs) + OUT_BITS'(rnd);
      OFF_MID:  off = OUT_BITS'(sf >> 1);
      OFF_ZERO: off = '0;
      default:  off = '0;
    endcase
  end

  // vertex coordinates
  always_comb begin
    basef[0] = {bx[15], bx, {FRAC_BITS{1'b0}}};
    basef[1] = {by[15], by, {FRAC_BITS{1'b0}}};
    basef[2] = {bz[15], bz, {FRAC_BITS{1'b0}}};
    p0 = corner_pos(c0);
    p1 = corner_pos(c1);
    for (int j = 0; j < 3; j++) begin
      crd[j] = basef[j] + (p0[j] ? OUT_BITS'(sf) : '0);
      if (p0[j] != p1[j]) begin
        crd[j] = p0[j] ? crd[j] - off : crd[j] + off;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_thresh     <= '0;
      min_difference <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ISO_THRESH:     iso_thresh     <= cfg_data;
        REG_MIN_DIFFERENCE: min_difference <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cv[0] <= corner_value_0;
      cv[1] <= corner_value_1;
      cv[2] <= corner_value_2;
      cv[3] <= corner_value_3;
      cv[4] <= corner_value_4;
      cv[5] <= corner_value_5;
      cv[6] <= corner_value_6;
      cv[7] <= corner_value_7;
      bx <= base_x;
      by <= base_y;
      bz <= base_z;
      cs <= cell_size;
    end
    if (cmd.lookup) begin
      row  <= ent[ROW_BITS-1:0] << sh;
      ntri <= ent[62:60];
    end
    if (cmd.rd0) begin
      c0 <= ends[5:3];
      c1 <= ends[2:0];
      v0 <= cv[rd_sel];
    end
    if (cmd.rd1) begin
      v1 <= cv[rd_sel];
    end
    if (cmd.calc) begin
      ad <= ad_w[15:0];
      aa <= (aa_w > ad_w) ? ad_w[15:0] : aa_w[15:0];
      if (ad_w == 17'd0 || ad_w < {1'b0, min_difference}) begin
        mode <= OFF_MID;
      end else if (a != 17'sd0 && (a[16] != d[16])) begin
        mode <= OFF_ZERO;
      end else begin
        mode <= OFF_DIV;
      end
    end
    if (cmd.mul) begin
      rem <= prod[PROD_BITS-1 -: 16];
      qs  <= prod[SF_BITS-1:0];
    end
    if (cmd.div_step) begin
      rem <= ge ? 16'(t - {1'b0, ad}) : t[15:0];
      qs  <= {qs[SF_BITS-2:0], ge};
    end
    if (cmd.fin) begin
      for (int j = 0; j < 3; j++) begin
        vtx[cmd.vert_idx][j] <= crd[j];
      end
    end
  end

  assign st.ntri = ntri;
  assign st.skip = (mode != OFF_DIV);

  assign first_x  = vtx[0][0];
  assign first_y  = vtx[0][1];
  assign first_z  = vtx[0][2];
  assign second_x = vtx[1][0];
  assign second_y = vtx[1][1];
  assign second_z = vtx[1][2];
  assign third_x  = vtx[2][0];
  assign third_y  = vtx[2][1];
  assign third_z  = vtx[2][2];
  assign last_triangle = (cmd.tri_idx == ntri - 3'd1);

endmodule
`default_nettype wire

// ===== sv/mcct_ctrl.sv =====
`default_nettype none
module mcct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  mcct_pkg::stat_t st,
  output mcct_pkg::cmd_t  cmd
);
  import mcct_pkg::*;
  `include "marching_cubes_cell_triangulator_top_assert.svh"

  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  state_t     state, state_next;
  logic [2:0] tri_cnt;
  logic [1:0] vert;
  logic [4:0] div_cnt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_RD0;
      ST_RD0:    state_next = (st.ntri == 3'd0) ? ST_IDLE : ST_RD1;
      ST_RD1:    state_next = ST_CALC;
      ST_CALC:   state_next = ST_MUL;
      ST_MUL:    state_next = st.skip ? ST_FIN : ST_DIV;
      ST_DIV:    if (div_cnt == DIV_LAST) state_next = ST_FIN;
      ST_FIN:    state_next = (vert == 2'd2) ? ST_EMIT : ST_RD0;
      ST_EMIT: begin
        if (!out_stall) begin
          state_next = (tri_cnt + 3'd1 == st.ntri) ? ST_IDLE : ST_RD0;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.lookup   = (state == ST_LOOKUP);
    cmd.rd0      = (state == ST_RD0);
    cmd.rd1      = (state == ST_RD1);
    cmd.calc     = (state == ST_CALC);
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.fin      = (state == ST_FIN);
    cmd.tri_idx  = tri_cnt;
    cmd.vert_idx = vert;
    in_stall     = (state != ST_IDLE);
    out_valid    = (state == ST_EMIT);
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tri_cnt <= '0;
      vert    <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOOKUP) begin
        tri_cnt <= '0;
        vert    <= '0;
      end
      if (state == ST_MUL) begin
        div_cnt <= '0;
      end
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 5'd1;
      end
      if (state == ST_FIN && vert != 2'd2) begin
        vert <= vert + 2'd1;
      end
      if (state == ST_EMIT && !out_stall) begin
        tri_cnt <= tri_cnt + 3'd1;
        vert    <= '0;
      end
    end
  end

  `MCCT_ASSERT_NEXT(a_accept_lookup, state == ST_IDLE && in_valid, state == ST_LOOKUP, "accept did not start lookup")
  `MCCT_ASSERT_NOW(a_emit_in_range, out_valid, tri_cnt < st.ntri, "triangle beyond count")
  `MCCT_ASSERT_NEXT(a_div_ends, state == ST_DIV && div_cnt == DIV_LAST, state == ST_FIN, "divider overran")
  `MCCT_ASSERT_NEXT(a_third_vertex, state == ST_FIN && vert == 2'd2, state == ST_EMIT, "triangle not emitted")

endmodule
`default_nettype wire

// ===== sv/marching_cubes_cell_triangulator_top.sv =====
// Cube index and table lookup first; then per vertex RD0, RD1, CALC, MUL and FIN, with
// the 24-step divider before FIN unless the point is a midpoint or an edge end.
// Cubes are taken one at a time; a cube without triangles ends after RD0, one with up
// to five triangles is bounded by the bit-serial divider and by out_stall at emit.
// Reset (rst, synchronous): controller to idle, iso threshold 0, min_difference 1.
`default_nettype none
module marching_cubes_cell_triangulator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  corner_value_0,
  input  logic signed [15:0]  corner_value_1,
  input  logic signed [15:0]  corner_value_2,
  input  logic signed [15:0]  corner_value_3,
  input  logic signed [15:0]  corner_value_4,
  input  logic signed [15:0]  corner_value_5,
  input  logic signed [15:0]  corner_value_6,
  input  logic signed [15:0]  corner_value_7,
  input  logic signed [15:0]  base_x,
  input  logic signed [15:0]  base_y,
  input  logic signed [15:0]  base_z,
  input  logic [15:0]         cell_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [24:0]  first_x,
  output logic signed [24:0]  first_y,
  output logic signed [24:0]  first_z,
  output logic signed [24:0]  second_x,
  output logic signed [24:0]  second_y,
  output logic signed [24:0]  second_z,
  output logic signed [24:0]  third_x,
  output logic signed [24:0]  third_y,
  output logic signed [24:0]  third_z,
  output logic                last_triangle
);
  import mcct_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  mcct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // lookup, interpolation and vertex registers
  mcct_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .corner_value_0 (corner_value_0),
    .corner_value_1 (corner_value_1),
    .corner_value_2 (corner_value_2),
    .corner_value_3 (corner_value_3),
    .corner_value_4 (corner_value_4),
    .corner_value_5 (corner_value_5),
    .corner_value_6 (corner_value_6),
    .corner_value_7 (corner_value_7),
    .base_x         (base_x),
    .base_y         (base_y),
    .base_z         (base_z),
    .cell_size      (cell_size),
    .cmd            (cmd),
    .st             (st),
    .first_x        (first_x),
    .first_y        (first_y),
    .first_z        (first_z),
    .second_x       (second_x),
    .second_y       (second_y),
    .second_z       (second_z),
    .third_x        (third_x),
    .third_y        (third_y),
    .third_z        (third_z),
    .last_triangle  (last_triangle)
  );

endmodule
`default_nettype wire
